>>> rtl/core/rbba_pkg.sv
// shared types and constants of the region bitmap block allocator
// no dependencies; imported by the bitmap memory and the top level
`timescale 1ns / 1ps
`default_nettype none

package rbba_pkg;

    localparam int REGIONS          = 4;
    localparam int MAX_BLOCKS       = 1024;
    localparam int WORD_WIDTH       = 64;
    localparam int WORDS_PER_REGION = (MAX_BLOCKS + WORD_WIDTH - 1) / WORD_WIDTH;

    localparam int REGION_W   = $clog2(REGIONS);
    localparam int WORD_IDX_W = $clog2(WORDS_PER_REGION);
    localparam int BIT_IDX_W  = $clog2(WORD_WIDTH);
    localparam int BLOCK_W    = WORD_IDX_W + BIT_IDX_W;
    localparam int COUNT_W    = BLOCK_W + 1;
    localparam int WC_W       = WORD_IDX_W + 1;
    localparam int NREG_W     = REGION_W + 1;
    localparam int MEM_DEPTH  = REGIONS * WORDS_PER_REGION;
    localparam int MEM_AW     = REGION_W + WORD_IDX_W;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGIONS = 1'd1;

    localparam logic [1:0] ACT_ASSIGN = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_FREE   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        word_t             wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_FREE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/region_bitmap_block_allocator_top.sv
// top level of the region bitmap block allocator: control, hints, round robin
// depends on rbba_pkg and rbba_bitmap_mem
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------
// request  | in        | in_valid/in_ready  | action, region, block_index
// result   | out       | out_valid/out_ready| status, region_out, block_out
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// assign and rejected requests pass through the result register to the output,
// free reads, modifies and writes back the bitmap word, allocate probes bitmap
// words from the hint, one memory read per cycle, until a free block is found
// or every word was probed.
// reset clears hints, the round robin counter and the per-word valid bits,
// so no clearing pass is needed. a stalled result sits in the output register
// while the next request is taken and worked on.

module region_bitmap_block_allocator_top
    import rbba_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [REGION_W-1:0]  region,
    input  wire logic [BLOCK_W-1:0]   block_index,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [REGION_W-1:0]       region_out,
    output logic [BLOCK_W-1:0]        block_out,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    function automatic word_t usable_mask(input logic [COUNT_W-1:0] cnt,
                                          input logic [WORD_IDX_W-1:0] w);
        logic [COUNT_W:0] base;
        logic [COUNT_W:0] top;
        word_t            m;
        base = (COUNT_W+1)'({w, {BIT_IDX_W{1'b0}}});
        top  = base + (COUNT_W+1)'(WORD_WIDTH);
        if ({1'b0, cnt} >= top)
        begin
            m = '1;
        end
        else if ({1'b0, cnt} <= base)
        begin
            m = '0;
        end
        else
        begin
            m = (word_t'(1) << cnt[BIT_IDX_W-1:0]) - word_t'(1);
        end
        return m;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] onehot_index(input word_t oh);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            idx = idx | (oh[i] ? BIT_IDX_W'(i) : '0);
        end
        return idx;
    endfunction

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        blocks_reg, blocks_next;
    logic [2:0]              nreg_cfg_reg, nreg_cfg_next;
    logic [REGION_W-1:0]     rr_reg, rr_next;
    logic [WORD_IDX_W-1:0]   hint_reg [REGIONS];
    logic [WORD_IDX_W-1:0]   hint_next [REGIONS];
    logic                    out_valid_reg, out_valid_next;

    logic [REGION_W-1:0]     req_region_reg, req_region_next;
    logic [BLOCK_W-1:0]      req_block_reg, req_block_next;
    logic [WORD_IDX_W-1:0]   chk_w_reg, chk_w_next;
    logic [WC_W-1:0]         chk_p_reg, chk_p_next;
    word_t                   avail_reg, avail_next;
    word_t                   word_reg, word_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic [REGION_W-1:0]     res_region_reg, res_region_next;
    logic [BLOCK_W-1:0]      res_block_reg, res_block_next;
    logic [1:0]              status_reg, status_next;
    logic [REGION_W-1:0]     region_out_reg, region_out_next;
    logic [BLOCK_W-1:0]      block_out_reg, block_out_next;

    mem_req_t                mreq;
    word_t                   rdata;

    logic [COUNT_W-1:0]      count;
    logic [COUNT_W:0]        count_up;
    logic [WC_W-1:0]         wc;
    logic [NREG_W-1:0]       nreg;
    logic                    in_region_ok;
    logic [NREG_W-1:0]       rr_pick;
    logic [NREG_W-1:0]       rr_inc;
    logic [WORD_IDX_W-1:0]   start_w;
    logic [WC_W-1:0]         scan_inc;
    logic [WORD_IDX_W-1:0]   scan_nxt;
    word_t                   scan_avail;
    word_t                   low_bit;
    logic                    accept;

    rbba_bitmap_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rdata)
    );

    always_comb
    begin
        count    = (blocks_reg > CFG_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                     : COUNT_W'(blocks_reg);
        count_up = {1'b0, count} + (COUNT_W+1)'(WORD_WIDTH - 1);
        wc       = count_up[BIT_IDX_W +: WC_W];
        if (nreg_cfg_reg == 3'd0)
        begin
            nreg = NREG_W'(1);
        end
        else if (NREG_W'(nreg_cfg_reg) > NREG_W'(REGIONS))
        begin
            nreg = NREG_W'(REGIONS);
        end
        else
        begin
            nreg = NREG_W'(nreg_cfg_reg);
        end
    end

    assign in_region_ok = (NREG_W'(region) < nreg);
    assign rr_pick      = (NREG_W'(rr_reg) < nreg) ? NREG_W'(rr_reg) : '0;
    assign rr_inc       = rr_pick + NREG_W'(1);
    assign start_w      = (WC_W'(hint_reg[region]) < wc) ? hint_reg[region] : '0;
    assign scan_inc     = WC_W'(chk_w_reg) + WC_W'(1);
    assign scan_nxt     = (scan_inc >= wc) ? '0 : scan_inc[WORD_IDX_W-1:0];
    assign scan_avail   = ~rdata & usable_mask(count, chk_w_reg);
    // isolate the lowest free bit
    assign low_bit      = avail_reg & (~avail_reg + word_t'(1));
    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        blocks_next     = blocks_reg;
        nreg_cfg_next   = nreg_cfg_reg;
        rr_next         = rr_reg;
        hint_next       = hint_reg;
        out_valid_next  = out_valid_reg;
        req_region_next = req_region_reg;
        req_block_next  = req_block_reg;
        chk_w_next      = chk_w_reg;
        chk_p_next      = chk_p_reg;
        avail_next      = avail_reg;
        word_next       = word_reg;
        res_status_next = res_status_reg;
        res_region_next = res_region_reg;
        res_block_next  = res_block_reg;
        status_next     = status_reg;
        region_out_next = region_out_reg;
        block_out_next  = block_out_reg;
        mreq.we         = 1'b0;
        mreq.waddr      = {req_region_reg, chk_w_reg};
        mreq.wdata      = word_reg | low_bit;
        mreq.raddr      = {req_region_reg, scan_nxt};

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCKS:  blocks_next   = cfg_data;
                CFG_REGIONS: nreg_cfg_next = cfg_data[2:0];
                default:     ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_region_next = region;
                    req_block_next  = block_index;
                    res_region_next = region;
                    res_block_next  = '0;
                    res_status_next = STAT_INVALID;
                    state_next      = ST_RESP;
                    unique case (action)
                        ACT_ASSIGN:
                        begin
                            res_region_next = rr_pick[REGION_W-1:0];
                            res_status_next = STAT_OK;
                            rr_next = (rr_inc >= nreg) ? '0 : rr_inc[REGION_W-1:0];
                        end
                        ACT_ALLOC:
                        begin
                            if (in_region_ok && wc == '0)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (in_region_ok)
                            begin
                                mreq.raddr = {region, start_w};
                                chk_w_next = start_w;
                                chk_p_next = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_FREE:
                        begin
                            res_block_next = block_index;
                            if (in_region_ok && COUNT_W'(block_index) < count)
                            begin
                                mreq.raddr = {region, block_index[BLOCK_W-1 -: WORD_IDX_W]};
                                state_next = ST_FREE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // next word is read speculatively while this one is checked
                if (scan_avail != '0)
                begin
                    avail_next = scan_avail;
                    word_next  = rdata;
                    state_next = ST_PICK;
                end
                else if (chk_p_reg + WC_W'(1) == wc)
                begin
                    res_status_next = STAT_FULL;
                    res_block_next  = '0;
                    state_next      = ST_RESP;
                end
                else
                begin
                    chk_w_next = scan_nxt;
                    chk_p_next = chk_p_reg + WC_W'(1);
                end
            end
            ST_PICK:
            begin
                mreq.we                   = 1'b1;
                hint_next[req_region_reg] = chk_w_reg;
                res_status_next           = STAT_OK;
                res_block_next            = {chk_w_reg, onehot_index(low_bit)};
                state_next                = ST_RESP;
            end
            ST_FREE:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = {req_region_reg, req_block_reg[BLOCK_W-1 -: WORD_IDX_W]};
                mreq.wdata = rdata & ~(word_t'(1) << req_block_reg[BIT_IDX_W-1:0]);
                hint_next[req_region_reg] = req_block_reg[BLOCK_W-1 -: WORD_IDX_W];
                res_status_next = STAT_OK;
                state_next      = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    region_out_next = res_region_reg;
                    block_out_next  = res_block_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            blocks_reg    <= CFG_W'(MAX_BLOCKS);
            nreg_cfg_reg  <= 3'(REGIONS);
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REGIONS; i++)
            begin
                hint_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            blocks_reg    <= blocks_next;
            nreg_cfg_reg  <= nreg_cfg_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
            hint_reg      <= hint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_region_reg <= req_region_next;
        req_block_reg  <= req_block_next;
        chk_w_reg      <= chk_w_next;
        chk_p_reg      <= chk_p_next;
        avail_reg      <= avail_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_region_reg <= res_region_next;
        res_block_reg  <= res_block_next;
        status_reg     <= status_next;
        region_out_reg <= region_out_next;
        block_out_reg  <= block_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign region_out = region_out_reg;
    assign block_out  = block_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/rbba_bitmap_mem.sv
// usage bitmap store: one word per region and word index, registered read
// depends on rbba_pkg; per-entry valid bits make unwritten words read as free
`timescale 1ns / 1ps
`default_nettype none

module rbba_bitmap_mem
    import rbba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output word_t         rdata
);

    word_t                mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    word_t                rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.raddr];
        end
    end

    // a word never written holds all blocks free
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> test/tb_region_bitmap_block_allocator_top.sv
// testbench for region_bitmap_block_allocator_top: directed and random requests, in-order checks
// depends on rbba_pkg and the allocator rtl; self-contained otherwise
`timescale 1ns / 1ps

module tb_region_bitmap_block_allocator_top;
    import rbba_pkg::*;

    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 7;

    typedef struct packed {
        logic [1:0]          status;
        logic [REGION_W-1:0] region;
        logic [BLOCK_W-1:0]  block;
    } grant_t;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM} ready_mode_t;

    class alloc_ledger;
        bit [WORD_WIDTH-1:0] usage [REGIONS][WORDS_PER_REGION];
        int unsigned hint [REGIONS];
        int unsigned next_region;
        int unsigned blocks_reg;
        int unsigned regions_reg;
        grant_t pending_grants[$];
        int mismatches;

        function new();
            foreach (usage[r, w]) usage[r][w] = '0;
            foreach (hint[r]) hint[r] = 0;
            next_region = 0;
            blocks_reg = MAX_BLOCKS;
            regions_reg = REGIONS;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_BLOCKS)
                blocks_reg = value;
            else if (idx == CFG_REGIONS)
                regions_reg = value[2:0];
        endfunction

        function int unsigned live_regions();
            if (regions_reg == 0)
                return 1;
            return (regions_reg > REGIONS) ? REGIONS : regions_reg;
        endfunction

        function int unsigned live_blocks();
            return (blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : blocks_reg;
        endfunction

        // bits of word w that lie below the block count
        function bit [WORD_WIDTH-1:0] usable_bits(int unsigned cnt, int unsigned w);
            int unsigned base;
            int unsigned left;
            base = w * WORD_WIDTH;
            if (cnt <= base)
                return '0;
            left = cnt - base;
            if (left >= WORD_WIDTH)
                return {WORD_WIDTH{1'b1}};
            return (64'd1 << left) - 64'd1;
        endfunction

        // index of a block in use where one exists, for well-formed frees
        function int pick_used(logic [REGION_W-1:0] rgn, int unsigned cnt);
            int unsigned start;
            int unsigned i;
            if (cnt == 0)
                return $urandom_range(0, MAX_BLOCKS - 1);
            start = $urandom_range(0, cnt - 1);
            for (int unsigned k = 0; k < cnt; k++)
            begin
                i = (start + k) % cnt;
                if (usage[rgn][i / WORD_WIDTH][i % WORD_WIDTH])
                    return i;
            end
            return start;
        endfunction

        function void note_request(logic [1:0] act, logic [REGION_W-1:0] rgn,
                                   logic [BLOCK_W-1:0] idx);
            int unsigned nreg;
            int unsigned cnt;
            int unsigned wc;
            int unsigned start;
            int unsigned w;
            int unsigned slot;
            int unsigned lo;
            bit [WORD_WIDTH-1:0] avail;
            grant_t g;
            nreg = live_regions();
            cnt = live_blocks();
            wc = (cnt + WORD_WIDTH - 1) / WORD_WIDTH;
            g.status = STAT_INVALID;
            g.region = rgn;
            g.block = '0;
            if (act == ACT_ASSIGN)
            begin
                // a counter left stale by a register change restarts at region 0
                slot = (next_region < nreg) ? next_region : 0;
                g.region = slot[REGION_W-1:0];
                next_region = (slot + 1 >= nreg) ? 0 : slot + 1;
                g.status = STAT_OK;
            end
            else if (act == ACT_ALLOC)
            begin
                if (rgn < nreg)
                begin
                    start = (hint[rgn] < wc) ? hint[rgn] : 0;
                    g.status = STAT_FULL;
                    for (int unsigned p = 0; p < wc && g.status == STAT_FULL; p++)
                    begin
                        w = start + p;
                        if (w >= wc)
                            w -= wc;
                        avail = ~usage[rgn][w] & usable_bits(cnt, w);
                        if (avail != 0)
                        begin
                            lo = 0;
                            while (!avail[lo])
                                lo++;
                            usage[rgn][w][lo] = 1'b1;
                            hint[rgn] = w;
                            g.block = BLOCK_W'(w * WORD_WIDTH + lo);
                            g.status = STAT_OK;
                        end
                    end
                end
            end
            else if (act == ACT_FREE)
            begin
                g.block = idx;
                if (rgn < nreg && idx < cnt)
                begin
                    usage[rgn][idx / WORD_WIDTH][idx % WORD_WIDTH] = 1'b0;
                    hint[rgn] = idx / WORD_WIDTH;
                    g.status = STAT_OK;
                end
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [1:0] s, logic [REGION_W-1:0] r, logic [BLOCK_W-1:0] b);
            grant_t want;
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: status %0d region %0d block %0d",
                             s, r, b);
                return;
            end
            want = pending_grants.pop_front();
            if (want.status !== s || want.region !== r || want.block !== b)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d region %0d block %0d, got %0d %0d %0d",
                             want.status, want.region, want.block, s, r, b);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           action;
    logic [REGION_W-1:0]  region;
    logic [BLOCK_W-1:0]   block_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic [REGION_W-1:0]  region_out;
    logic [BLOCK_W-1:0]   block_out;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    alloc_ledger ledger;
    int burst_left;
    int stall_left;
    ready_mode_t ready_mode;

    int unsigned plan_blocks [PHASES]  = '{1024, 64, 1, 100, 0, 2047, 65};
    int unsigned plan_regions [PHASES] = '{4, 1, 2, 3, 1, 7, 2};
    int unsigned plan_items [PHASES]   = '{180, 150, 40, 120, 20, 140, 200};

    region_bitmap_block_allocator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .region      (region),
        .block_index (block_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .region_out  (region_out),
        .block_out   (block_out),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // both channels are sampled before the edge updates anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ledger.note_request(action, region, block_index);
            if (out_valid && out_ready)
                ledger.check_grant(status, region_out, block_out);
        end
    end

    // receiver back-pressure: runs of always ready, mostly ready and seldom ready
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            default:      out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_region_bitmap_block_allocator_top: errors");
        $finish;
    end

    task automatic send_request(logic [1:0] act, logic [REGION_W-1:0] rgn,
                                logic [BLOCK_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        region <= rgn;
        block_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // wait for an edge first so the transfer just taken is already in the ledger
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (ledger.pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(int unsigned blocks, int unsigned regions);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BLOCKS;
        cfg_data <= CFG_W'(blocks);
        @(posedge clk);
        ledger.write_reg(CFG_BLOCKS, CFG_W'(blocks));
        cfg_index <= CFG_REGIONS;
        cfg_data <= CFG_W'(regions);
        @(posedge clk);
        ledger.write_reg(CFG_REGIONS, CFG_W'(regions));
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int unsigned roll;
        int unsigned nreg;
        int idx;
        logic [REGION_W-1:0] rgn;
        roll = $urandom_range(0, 99);
        nreg = ledger.live_regions();
        rgn = ($urandom_range(0, 9) == 0) ? REGION_W'($urandom)
                                          : REGION_W'($urandom_range(0, nreg - 1));
        if (roll < 6)
            send_request(ACT_ASSIGN, REGION_W'($urandom), BLOCK_W'($urandom));
        else if (roll < 71)
            send_request(ACT_ALLOC, rgn, BLOCK_W'($urandom));
        else if (roll < 93)
        begin
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BLOCKS - 1)
                                              : ledger.pick_used(rgn, ledger.live_blocks());
            send_request(ACT_FREE, rgn, BLOCK_W'(idx));
        end
        else
            send_request(ACT_UNDEFINED, REGION_W'($urandom), BLOCK_W'($urandom));
    endtask

    initial
    begin
        ledger = new();
        burst_left = 0;
        stall_left = 0;
        ready_mode = READY_ALWAYS;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_ASSIGN;
        region = '0;
        block_index = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BLOCKS;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: round robin, next fit from the hint word, unknown action
        send_request(ACT_ASSIGN, 2'd3, 10'd1023);
        send_request(ACT_ASSIGN, 2'd0, 10'd0);
        send_request(ACT_ASSIGN, 2'd1, 10'd0);
        send_request(ACT_ALLOC, 2'd0, 10'd0);
        send_request(ACT_ALLOC, 2'd3, 10'd1023);
        send_request(ACT_FREE, 2'd0, 10'd1023);
        send_request(ACT_FREE, 2'd1, 10'd0);
        send_request(ACT_UNDEFINED, 2'd2, 10'd1023);
        send_request(ACT_ALLOC, 2'd0, 10'd0);

        // stale counter and stale hint, region and index out of range
        configure(64, 2);
        send_request(ACT_ASSIGN, 2'd0, 10'd0);
        send_request(ACT_ALLOC, 2'd0, 10'd0);
        send_request(ACT_ALLOC, 2'd2, 10'd0);
        send_request(ACT_FREE, 2'd3, 10'd5);
        send_request(ACT_FREE, 2'd0, 10'd64);

        // no usable blocks, regions in use of zero
        configure(0, 0);
        send_request(ACT_ALLOC, 2'd0, 10'd0);
        send_request(ACT_FREE, 2'd0, 10'd0);
        send_request(ACT_ASSIGN, 2'd0, 10'd0);
        send_request(ACT_ASSIGN, 2'd0, 10'd0);

        // both registers above their maxima
        configure(2047, 7);
        send_request(ACT_ALLOC, 2'd3, 10'd0);
        send_request(ACT_FREE, 2'd3, 10'd1023);
        send_request(ACT_ALLOC, 2'd1, 10'd0);

        // single block: full, free, refill
        configure(1, 1);
        send_request(ACT_ALLOC, 2'd0, 10'd0);
        send_request(ACT_FREE, 2'd0, 10'd0);
        send_request(ACT_ALLOC, 2'd0, 10'd0);
        send_request(ACT_ALLOC, 2'd0, 10'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            configure(plan_blocks[ph], plan_regions[ph]);
            for (int unsigned n = 0; n < plan_items[ph]; n++)
                random_request();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0)
            $display("tb_region_bitmap_block_allocator_top: clean");
        else
            $display("tb_region_bitmap_block_allocator_top: errors");
        $finish;
    end

endmodule
